### src/lprd_pkg.sv
// Shared types and constants for the length-prefixed record deframer.
`default_nettype none

package lprd_pkg;

    // Default width of the decoded length and the byte countdown
    localparam int LENGTH_BITS_DEF = 32;

    // Width of the record_length field on the result word
    localparam int RECORD_LENGTH_W = 32;

    // Varint coding: value bits per byte, value mask, continuation flag position
    localparam int         PAYLOAD_BITS = 7;
    localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
    localparam int         MORE_BIT     = 7;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_TRUNC_VARINT = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW     = 2'd2;
    localparam logic [1:0] ERR_TRUNC_VALUE  = 2'd3;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [1:0]                 kind;
        logic [RECORD_LENGTH_W-1:0] record_length;
        logic [7:0]                 payload_byte;
        logic                       last_of_record;
        logic [1:0]                 error_code;
    } out_word_t;

    // Result of one parse step, handed to the output register
    typedef struct packed {
        logic      valid;
        out_word_t word;
    } step_res_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_LENGTH  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DRAIN   = 3'b100
    } phase_t;

endpackage

`default_nettype wire

### src/lprd_parser.sv
// Parser state and single-step decode of one input word.
`default_nettype none

module lprd_parser #(
    parameter int LENGTH_BITS = lprd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire lprd_pkg::in_word_t in_word,
    output lprd_pkg::step_res_t    res
);

    localparam int MAX_BYTES = (LENGTH_BITS + lprd_pkg::PAYLOAD_BITS - 1) /
                               lprd_pkg::PAYLOAD_BITS;
    localparam int CNT_W     = $clog2(MAX_BYTES);
    localparam int SH_W      = $clog2(LENGTH_BITS);

    lprd_pkg::phase_t       phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    logic [SH_W-1:0]        shift_amt;
    logic [LENGTH_BITS-1:0] acc_new;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [lprd_pkg::RECORD_LENGTH_W-1:0] len_out;
    logic                   more;

    // Merge the 7 value bits of this length byte at its slot; high bits fall off
    assign shift_amt = SH_W'(cnt_reg) * SH_W'(lprd_pkg::PAYLOAD_BITS);
    assign acc_new   = acc_reg | ({{(LENGTH_BITS-7){1'b0}},
                                  in_word.data_byte[6:0]} << shift_amt);
    assign rem_dec   = rem_reg - LENGTH_BITS'(1);
    assign more      = in_word.data_byte[lprd_pkg::MORE_BIT];

    // Low 32 bits of the decoded length, zero-extended for narrow lengths
    generate
        if (LENGTH_BITS >= lprd_pkg::RECORD_LENGTH_W) begin : g_len_trunc
            assign len_out = acc_new[lprd_pkg::RECORD_LENGTH_W-1:0];
        end else begin : g_len_ext
            assign len_out = {{(lprd_pkg::RECORD_LENGTH_W-LENGTH_BITS){1'b0}}, acc_new};
        end
    endgenerate

    // Next state and result for one accepted word
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        res        = '0;
        if (step_en) begin
            if (in_word.end_of_input) begin
                case (phase_reg)
                    lprd_pkg::PH_DRAIN: begin
                    end
                    lprd_pkg::PH_PAYLOAD: begin
                        res.valid           = 1'b1;
                        res.word.kind       = lprd_pkg::KIND_ERROR;
                        res.word.error_code = lprd_pkg::ERR_TRUNC_VALUE;
                    end
                    default: begin
                        res.valid = 1'b1;
                        if (cnt_reg != '0) begin
                            res.word.kind       = lprd_pkg::KIND_ERROR;
                            res.word.error_code = lprd_pkg::ERR_TRUNC_VARINT;
                        end else begin
                            res.word.kind = lprd_pkg::KIND_END;
                        end
                    end
                endcase
                phase_next = lprd_pkg::PH_LENGTH;
                acc_next   = '0;
                cnt_next   = '0;
                rem_next   = '0;
            end else begin
                case (phase_reg)
                    lprd_pkg::PH_DRAIN: begin
                    end
                    lprd_pkg::PH_PAYLOAD: begin
                        res.valid             = 1'b1;
                        res.word.kind         = lprd_pkg::KIND_PAYLOAD;
                        res.word.payload_byte = in_word.data_byte;
                        if (rem_dec == '0) begin
                            res.word.last_of_record = 1'b1;
                            phase_next = lprd_pkg::PH_LENGTH;
                            acc_next   = '0;
                            cnt_next   = '0;
                            rem_next   = '0;
                        end else begin
                            rem_next = rem_dec;
                        end
                    end
                    lprd_pkg::PH_LENGTH: begin
                        if (!more) begin
                            // Length complete: header, then payload unless empty
                            res.valid     = 1'b1;
                            res.word.kind = lprd_pkg::KIND_HEADER;
                            acc_next      = '0;
                            cnt_next      = '0;
                            if (acc_new == '0) begin
                                res.word.last_of_record = 1'b1;
                                phase_next = lprd_pkg::PH_LENGTH;
                                rem_next   = '0;
                            end else begin
                                res.word.record_length = len_out;
                                phase_next = lprd_pkg::PH_PAYLOAD;
                                rem_next   = acc_new;
                            end
                        end else if (cnt_reg == CNT_W'(MAX_BYTES - 1)) begin
                            // Continuation on the final allowed byte
                            res.valid           = 1'b1;
                            res.word.kind       = lprd_pkg::KIND_ERROR;
                            res.word.error_code = lprd_pkg::ERR_OVERFLOW;
                            phase_next = lprd_pkg::PH_DRAIN;
                            acc_next   = '0;
                            cnt_next   = '0;
                            rem_next   = '0;
                        end else begin
                            acc_next = acc_new;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                        phase_next = lprd_pkg::PH_LENGTH;
                        acc_next   = '0;
                        cnt_next   = '0;
                        rem_next   = '0;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lprd_pkg::PH_LENGTH;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
        end
    end

    // An end marker always brings the parser back to the length phase
    a_eoi_to_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && in_word.end_of_input) |=> (phase_reg == lprd_pkg::PH_LENGTH))
        else $error("end marker did not return parser to length phase");

    // Overflow error enters the drain phase
    a_overflow_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.word.kind == lprd_pkg::KIND_ERROR &&
         res.word.error_code == lprd_pkg::ERR_OVERFLOW) |=>
        (phase_reg == lprd_pkg::PH_DRAIN))
        else $error("overflow did not enter drain phase");

    // Payload phase always has bytes outstanding
    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == lprd_pkg::PH_PAYLOAD) |-> (rem_reg != '0))
        else $error("payload phase with zero bytes remaining");

    // Length byte count stays inside the allowed varint size; zero count and accumulator outside the length phase
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cnt_reg) < MAX_BYTES) && ((phase_reg != lprd_pkg::PH_LENGTH) ->
        (cnt_reg == '0 && acc_reg == '0)))
        else $error("length byte count or accumulator out of range");

endmodule

`default_nettype wire

### src/lprd_out_reg.sv
// Result register between the parser and the result channel.
`default_nettype none

module lprd_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lprd_pkg::step_res_t res,
    input  wire logic                step_en,
    output logic                     free,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lprd_pkg::out_word_t      m_data
);

    logic                valid_reg;
    lprd_pkg::out_word_t data_reg;
    logic                load;

    // Room for a new result when empty or when the held word leaves now
    assign free    = !valid_reg || m_ready;
    assign load    = step_en && res.valid;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res.word;
        end
    end

endmodule

`default_nettype wire

### src/length_prefixed_record_deframer_core.sv
// Top level of the length-prefixed record deframer.
//
// Input channel (s_valid/s_ready/s_data): one word per byte of the stream, or an
// end marker with end_of_input set. Each record is a little-endian base-128
// varint length followed by that many payload bytes.
// Result channel (m_valid/m_ready/m_data): header, payload byte, clean end or
// error words, at most one per input word; length bytes before the last, bytes
// in the drain phase and the end marker that closes a drain give none.
// A result appears on m_valid in the cycle after its input word is taken.
// Throughput: one input word per cycle while the receiver keeps up; the parse
// step is one layer of logic between the parser state and the result register.
// When the receiver stalls, the result register holds its word and s_ready
// drops until it is taken; s_ready is high whenever the register is empty or
// being emptied in the same cycle.
// Reset (aresetn low, synchronous) returns the parser to the length phase
// with an empty accumulator and empties the result register.
`default_nettype none

module length_prefixed_record_deframer_core #(
    parameter int LENGTH_BITS = lprd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lprd_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lprd_pkg::out_word_t      m_data
);

    logic                step_en;
    lprd_pkg::step_res_t res;

    assign step_en = s_valid && s_ready;

    // Parse state and decode
    lprd_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .in_word (s_data),
        .res     (res)
    );

    // Result register
    lprd_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .res     (res),
        .step_en (step_en),
        .free    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### dv/length_prefixed_record_deframer_core_tb.sv
// Testbench for the length-prefixed record deframer: directed and random streams checked against a predictor.
`timescale 1ns / 1ps

// Predicts the deframer's result words and checks the words that come out
class record_scoreboard;
    localparam int LEN_MAX_BYTES = (lprd_pkg::LENGTH_BITS_DEF + 6) / 7;

    lprd_pkg::out_word_t expected_q[$];
    lprd_pkg::phase_t    phase;
    logic [31:0]         len_acc;
    int unsigned         len_bytes;
    logic [31:0]         remaining;
    int                  mismatches;

    function new();
        back_to_length();
        mismatches = 0;
    endfunction

    function void back_to_length();
        phase     = lprd_pkg::PH_LENGTH;
        len_acc   = '0;
        len_bytes = 0;
        remaining = '0;
    endfunction

    function void expect_word(logic [1:0] kind, logic [31:0] len, logic [7:0] data,
                              logic last, logic [1:0] err);
        lprd_pkg::out_word_t w;
        w.kind           = kind;
        w.record_length  = len;
        w.payload_byte   = data;
        w.last_of_record = last;
        w.error_code     = err;
        expected_q = {expected_q, w};
    endfunction

    // One accepted input word: advance the parser copy, queue any result
    function void note_input(input lprd_pkg::in_word_t w);
        logic [63:0] wide;
        if (w.end_of_input) begin
            if (phase == lprd_pkg::PH_PAYLOAD)
                expect_word(lprd_pkg::KIND_ERROR, '0, '0, 1'b0,
                            lprd_pkg::ERR_TRUNC_VALUE);
            else if (phase == lprd_pkg::PH_LENGTH && len_bytes != 0)
                expect_word(lprd_pkg::KIND_ERROR, '0, '0, 1'b0,
                            lprd_pkg::ERR_TRUNC_VARINT);
            else if (phase == lprd_pkg::PH_LENGTH)
                expect_word(lprd_pkg::KIND_END, '0, '0, 1'b0, lprd_pkg::ERR_NONE);
            back_to_length();
            return;
        end
        if (phase == lprd_pkg::PH_DRAIN)
            return;
        if (phase == lprd_pkg::PH_PAYLOAD) begin
            remaining = remaining - 32'd1;
            if (remaining == 0) begin
                expect_word(lprd_pkg::KIND_PAYLOAD, '0, w.data_byte, 1'b1,
                            lprd_pkg::ERR_NONE);
                back_to_length();
            end else begin
                expect_word(lprd_pkg::KIND_PAYLOAD, '0, w.data_byte, 1'b0,
                            lprd_pkg::ERR_NONE);
            end
            return;
        end
        // length phase: value bits above bit 31 fall off
        wide = {32'd0, len_acc} |
               (64'(w.data_byte & lprd_pkg::PAYLOAD_MASK) <<
                (len_bytes * lprd_pkg::PAYLOAD_BITS));
        len_acc = wide[31:0];
        if (!w.data_byte[lprd_pkg::MORE_BIT]) begin
            if (len_acc == 0) begin
                expect_word(lprd_pkg::KIND_HEADER, '0, '0, 1'b1, lprd_pkg::ERR_NONE);
                back_to_length();
            end else begin
                expect_word(lprd_pkg::KIND_HEADER, len_acc, '0, 1'b0, lprd_pkg::ERR_NONE);
                remaining = len_acc;
                phase     = lprd_pkg::PH_PAYLOAD;
                len_acc   = '0;
                len_bytes = 0;
            end
        end else if (len_bytes + 1 >= LEN_MAX_BYTES) begin
            expect_word(lprd_pkg::KIND_ERROR, '0, '0, 1'b0, lprd_pkg::ERR_OVERFLOW);
            back_to_length();
            phase = lprd_pkg::PH_DRAIN;
        end else begin
            len_bytes++;
        end
    endfunction

    // One accepted result word against the oldest expectation
    function void check_result(input lprd_pkg::out_word_t got);
        lprd_pkg::out_word_t exp;
        bit                  bad;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind=%0d len=%h byte=%h last=%b err=%0d",
                         got.kind, got.record_length, got.payload_byte,
                         got.last_of_record, got.error_code);
            return;
        end
        exp = expected_q.pop_front();
        bad = (got.kind !== exp.kind) || (got.record_length !== exp.record_length) ||
              (got.payload_byte !== exp.payload_byte) ||
              (got.last_of_record !== exp.last_of_record) ||
              (got.error_code !== exp.error_code);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp kind=%0d len=%h byte=%h last=%b err=%0d",
                          " | got kind=%0d len=%h byte=%h last=%b err=%0d"},
                         exp.kind, exp.record_length, exp.payload_byte,
                         exp.last_of_record, exp.error_code,
                         got.kind, got.record_length, got.payload_byte,
                         got.last_of_record, got.error_code);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module length_prefixed_record_deframer_core_tb;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    lprd_pkg::in_word_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    lprd_pkg::out_word_t m_data;

    record_scoreboard sb = new();

    bit burst    = 1'b0;  // no idling on either side while set
    bit in_drain = 1'b0;  // words sent now are dropped by the block
    int counted  = 0;

    length_prefixed_record_deframer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        if (burst)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Present one word and hold it until it is taken
    task automatic send_word(input lprd_pkg::in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(w);
        if (!in_drain)
            counted++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        lprd_pkg::in_word_t w;
        w.data_byte    = b;
        w.end_of_input = 1'b0;
        send_word(w);
    endtask

    // End marker; the data byte is don't-care, so randomize it
    task automatic send_end();
        lprd_pkg::in_word_t w;
        w.data_byte    = 8'($urandom);
        w.end_of_input = 1'b1;
        send_word(w);
    endtask

    // Varint length, optionally padded to more bytes; junk goes above bit 31
    task automatic send_length(input logic [31:0] len, input int pad, input logic [2:0] junk);
        logic [7:0]  grp[5];
        logic [31:0] v;
        logic [7:0]  b;
        int          n;
        int          total;
        n = 0;
        v = len;
        do begin
            grp[n] = {1'b0, v[6:0]};
            v = v >> 7;
            n++;
        end while (v != 0);
        total = (n + pad > 5) ? 5 : n + pad;
        for (int i = 0; i < total; i++) begin
            b = (i < n) ? grp[i] : 8'h00;
            if (i < total - 1)
                b[lprd_pkg::MORE_BIT] = 1'b1;
            if (i == 4)
                b[6:4] = junk;
            send_byte(b);
        end
    endtask

    task automatic run_directed();
        send_end();                         // clean end at a record boundary
        send_byte(8'h00);                   // zero length
        send_byte(8'h01);
        send_byte(8'hA5);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h81);                   // end inside a length
        send_end();
        send_byte(8'h03);                   // end inside a payload
        send_byte(8'h11);
        send_end();
        send_byte(8'hFF);                   // largest length, top bits discarded
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_end();
        send_byte(8'h80);                   // varint overflow, then drain
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        in_drain = 1'b1;
        send_byte(8'h12);
        send_end();
        in_drain = 1'b0;
    endtask

    task automatic run_random();
        int          sel;
        int          cnt;
        logic [31:0] len;
        while (counted < 1200) begin
            if ($urandom_range(0, 15) == 0)
                burst = ~burst;
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                // well-formed record with random content
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(0, 8);
                    6, 7, 8:          len = $urandom_range(9, 40);
                    default:          len = $urandom_range(41, 200);
                endcase
                send_length(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0,
                            3'($urandom));
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom));
                if ($urandom_range(0, 9) == 0)
                    send_end();
            end else if (sel < 78) begin
                // huge length, cut short by the end marker
                len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
                send_length(len, 0, 3'($urandom));
                cnt = $urandom_range(0, 8);
                for (int i = 0; i < cnt; i++)
                    send_byte(8'($urandom));
                send_end();
            end else if (sel < 85) begin
                // length cut short
                cnt = $urandom_range(1, 4);
                for (int i = 0; i < cnt; i++)
                    send_byte(8'h80 | 8'($urandom));
                send_end();
            end else if (sel < 90) begin
                // overflow, then bytes to drop
                for (int i = 0; i < 5; i++)
                    send_byte(8'h80 | 8'($urandom));
                in_drain = 1'b1;
                cnt = $urandom_range(0, 6);
                for (int i = 0; i < cnt; i++)
                    send_byte(8'($urandom));
                send_end();
                in_drain = 1'b0;
            end else if (sel < 95) begin
                // payload cut short
                len = $urandom_range(2, 12);
                send_length(len, 0, 3'd0);
                cnt = $urandom_range(0, len - 1);
                for (int i = 0; i < cnt; i++)
                    send_byte(8'($urandom));
                send_end();
            end else begin
                // noise, then resync with an end marker
                cnt = $urandom_range(1, 8);
                for (int i = 0; i < cnt; i++) begin
                    if ($urandom_range(0, 7) == 0)
                        send_end();
                    else
                        send_byte(8'($urandom));
                end
                send_end();
            end
        end
    endtask

    // Receiver: random stalls, check each taken word
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_result(m_data);
        end
    end

    // Sender and end of run
    initial begin
        int guard;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_valid <= 1'b0;
        burst = 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
